### rtl/core/sobel_gradient_rgb_core_macros.svh
// Assertion shorthands shared by the core.
`ifndef SOBEL_GRADIENT_RGB_CORE_MACROS_SVH
`define SOBEL_GRADIENT_RGB_CORE_MACROS_SVH

// cons must hold in the same cycle as ante
`define SGR_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// cons must hold in the cycle after ante
`define SGR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

// cond must hold on every cycle out of reset
`define SGR_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: invariant check failed");

`endif

### rtl/core/sgr_pkg.sv
package sgr_pkg;

   localparam int CHAN_W  = 8;
   localparam int GRAD_W  = 11;
   localparam int COORD_W = 11;
   localparam int CSR_W   = 12;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION  = 1'b1;

   localparam logic [CSR_W-1:0] LINE_WIDTH_RESET = 12'd640;
   localparam int LINE_WIDTH_MIN = 3;

   localparam logic DIR_X = 1'b0;
   localparam logic DIR_Y = 1'b1;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W     = 2;
   localparam int FIFO_CNT_W     = 3;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] grad_red;
      logic signed [GRAD_W-1:0] grad_green;
      logic signed [GRAD_W-1:0] grad_blue;
      logic [COORD_W-1:0]       center_column;
      logic [COORD_W-1:0]       center_row;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ls_ctl_type;

endpackage

### rtl/core/sgr_line_store.sv
// Two line memories, read-modify-write with registered read data.
module sgr_line_store #(
   parameter int MAX_WIDTH = 2048,
   localparam int IDX_W = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sgr_pkg::ls_ctl_type   ctl,
   input  logic [IDX_W-1:0]      rd_idx,
   input  logic [IDX_W-1:0]      wr_idx,
   input  sgr_pkg::pixel_type    wr_upper,
   input  sgr_pkg::pixel_type    wr_middle,
   output sgr_pkg::pixel_type    rd_upper,
   output sgr_pkg::pixel_type    rd_middle
);

   sgr_pkg::pixel_type upper_mem [MAX_WIDTH];
   sgr_pkg::pixel_type middle_mem [MAX_WIDTH];

   sgr_pkg::pixel_type upper_q_ff, middle_q_ff;
   sgr_pkg::pixel_type fwd_upper_ff, fwd_middle_ff;
   logic               fwd_ff, fwd_in;

   // same-edge write to the entry being read: memory returns old data
   assign fwd_in = ctl.rd_en && ctl.wr_en && (rd_idx == wr_idx);

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         upper_mem[wr_idx]  <= wr_upper;
         middle_mem[wr_idx] <= wr_middle;
      end
      if (ctl.rd_en) begin
         upper_q_ff  <= upper_mem[rd_idx];
         middle_q_ff <= middle_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      fwd_upper_ff  <= wr_upper;
      fwd_middle_ff <= wr_middle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_upper  = fwd_ff ? fwd_upper_ff  : upper_q_ff;
   assign rd_middle = fwd_ff ? fwd_middle_ff : middle_q_ff;

endmodule

### rtl/core/sgr_window.sv
// 3x3 window registers and per-channel Sobel sums.
module sgr_window (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                shift,
   input  sgr_pkg::pixel_type                  pix_upper,
   input  sgr_pkg::pixel_type                  pix_middle,
   input  sgr_pkg::pixel_type                  pix_new,
   input  logic                                direction,
   output logic signed [sgr_pkg::GRAD_W-1:0]   grad_red,
   output logic signed [sgr_pkg::GRAD_W-1:0]   grad_green,
   output logic signed [sgr_pkg::GRAD_W-1:0]   grad_blue
);

   // row-major: 0..2 top (oldest line), 6..8 bottom (current line)
   sgr_pkg::pixel_type win_ff [9];

   function automatic logic signed [sgr_pkg::GRAD_W-1:0] tap_diff(
      input logic [sgr_pkg::CHAN_W-1:0] p0,
      input logic [sgr_pkg::CHAN_W-1:0] p1,
      input logic [sgr_pkg::CHAN_W-1:0] p2,
      input logic [sgr_pkg::CHAN_W-1:0] n0,
      input logic [sgr_pkg::CHAN_W-1:0] n1,
      input logic [sgr_pkg::CHAN_W-1:0] n2
   );
      logic [sgr_pkg::GRAD_W-1:0] pos;
      logic [sgr_pkg::GRAD_W-1:0] neg;
      pos = sgr_pkg::GRAD_W'(p0) + (sgr_pkg::GRAD_W'(p1) << 1) + sgr_pkg::GRAD_W'(p2);
      neg = sgr_pkg::GRAD_W'(n0) + (sgr_pkg::GRAD_W'(n1) << 1) + sgr_pkg::GRAD_W'(n2);
      return signed'(pos - neg);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]   <= win_ff[r*3+1];
            win_ff[r*3+1] <= win_ff[r*3+2];
         end
         win_ff[2] <= pix_upper;
         win_ff[5] <= pix_middle;
         win_ff[8] <= pix_new;
      end
   end

   always_comb begin
      unique case (direction)
         sgr_pkg::DIR_X: begin
            grad_red   = tap_diff(win_ff[2].red,   win_ff[5].red,   win_ff[8].red,
                                  win_ff[0].red,   win_ff[3].red,   win_ff[6].red);
            grad_green = tap_diff(win_ff[2].green, win_ff[5].green, win_ff[8].green,
                                  win_ff[0].green, win_ff[3].green, win_ff[6].green);
            grad_blue  = tap_diff(win_ff[2].blue,  win_ff[5].blue,  win_ff[8].blue,
                                  win_ff[0].blue,  win_ff[3].blue,  win_ff[6].blue);
         end
         sgr_pkg::DIR_Y: begin
            grad_red   = tap_diff(win_ff[6].red,   win_ff[7].red,   win_ff[8].red,
                                  win_ff[0].red,   win_ff[1].red,   win_ff[2].red);
            grad_green = tap_diff(win_ff[6].green, win_ff[7].green, win_ff[8].green,
                                  win_ff[0].green, win_ff[1].green, win_ff[2].green);
            grad_blue  = tap_diff(win_ff[6].blue,  win_ff[7].blue,  win_ff[8].blue,
                                  win_ff[0].blue,  win_ff[1].blue,  win_ff[2].blue);
         end
         default: begin
            grad_red   = '0;
            grad_green = '0;
            grad_blue  = '0;
         end
      endcase
   end

endmodule

### rtl/core/sgr_rsp_fifo.sv
// Small result queue in front of the response channel.
module sgr_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  sgr_pkg::rsp_type                  push_data,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output sgr_pkg::rsp_type                  rsp_data,
   output logic [sgr_pkg::FIFO_CNT_W-1:0]    count
);

   sgr_pkg::rsp_type                   entry_ff [sgr_pkg::RSP_FIFO_DEPTH];
   logic [sgr_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [sgr_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [sgr_pkg::FIFO_CNT_W-1:0]     count_ff, count_in;
   logic                               pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + sgr_pkg::FIFO_CNT_W'(push) - sgr_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/sobel_gradient_rgb_core.sv
// 3x3 Sobel gradient of an RGB raster stream. One pixel request is taken per
// clock, sustained while the response side does not stall. Each pixel reads
// its column from two line memories on the accept edge, writes the shifted
// column back the next cycle, and pushes a result into a four-entry queue in
// the cycle after that, from where it goes out on rsp_. req_stall rises only
// in reset or when the queue plus the two pipeline slots would exceed four
// results, i.e. when the response side has stalled. Results are signed
// 11-bit integer sums for red, green and blue, horizontal (right minus left)
// or vertical (bottom minus top) per the direction register; border pixels
// (row or column below 2) produce no result. start_of_frame places its pixel
// at (0,0). Line width is clamped to 3..MAX_WIDTH. The line memories hold no
// reset state and need no clearing.
`include "sobel_gradient_rgb_core_macros.svh"

module sobel_gradient_rgb_core #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel requests
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sgr_pkg::CHAN_W-1:0]          req_red,
   input  logic [sgr_pkg::CHAN_W-1:0]          req_green,
   input  logic [sgr_pkg::CHAN_W-1:0]          req_blue,
   input  logic                                req_start_of_frame,
   // gradient results
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sgr_pkg::GRAD_W-1:0]   rsp_grad_red,
   output logic signed [sgr_pkg::GRAD_W-1:0]   rsp_grad_green,
   output logic signed [sgr_pkg::GRAD_W-1:0]   rsp_grad_blue,
   output logic [sgr_pkg::COORD_W-1:0]         rsp_center_column,
   output logic [sgr_pkg::COORD_W-1:0]         rsp_center_row,
   // register writes
   input  logic                                csr_write,
   input  logic [sgr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sgr_pkg::CSR_W-1:0]           csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WMAX_W = $clog2(MAX_WIDTH + 1);
   // width compare domain: holds both the register and MAX_WIDTH
   localparam int WW = (sgr_pkg::CSR_W > WMAX_W) ? sgr_pkg::CSR_W : WMAX_W;
   localparam int CR_W = sgr_pkg::FIFO_CNT_W + 1;

   // ---------------- registers ----------------
   logic [sgr_pkg::CSR_W-1:0]  line_width_ff;
   logic                       direction_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= sgr_pkg::LINE_WIDTH_RESET;
         direction_ff  <= sgr_pkg::DIR_X;
      end else if (csr_write) begin
         unique case (csr_index)
            sgr_pkg::CSR_LINE_WIDTH: line_width_ff <= csr_data;
            sgr_pkg::CSR_DIRECTION:  direction_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // width in use, clamped
   logic [WW-1:0] width_raw, width_use;
   always_comb begin
      width_raw = WW'(line_width_ff);
      priority if (width_raw < WW'(sgr_pkg::LINE_WIDTH_MIN)) begin
         width_use = WW'(sgr_pkg::LINE_WIDTH_MIN);
      end else if (width_raw > WW'(MAX_WIDTH)) begin
         width_use = WW'(MAX_WIDTH);
      end else begin
         width_use = width_raw;
      end
   end

   // ---------------- stage 0: accept, count position ----------------
   logic                        req_accept;
   logic [CR_W-1:0]             in_flight;
   logic [sgr_pkg::FIFO_CNT_W-1:0] fifo_count;
   logic                        s1_valid_ff, s1_produce_ff;
   logic                        s2_push_ff;

   // every accepted pixel may still owe a queue slot; count them all
   assign in_flight  = CR_W'(fifo_count) + CR_W'(s1_valid_ff) + CR_W'(s2_push_ff);
   assign req_stall  = reset || (in_flight >= CR_W'(sgr_pkg::RSP_FIFO_DEPTH));
   assign req_accept = req_valid && !req_stall;

   logic [CW-1:0] col_ff, col_in, col_cur;
   logic [RW-1:0] row_ff, row_in, row_cur;
   logic          line_end;
   logic          produce;

   always_comb begin
      col_cur  = req_start_of_frame ? '0 : col_ff;
      row_cur  = req_start_of_frame ? '0 : row_ff;
      line_end = (WW'(col_cur) + WW'(1)) >= width_use;
      produce  = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
      col_in   = col_ff;
      row_in   = row_ff;
      if (req_accept) begin
         if (line_end) begin
            col_in = '0;
            // past the last row: wrap as a fresh frame
            if ((RW'(1) + row_cur) == RW'(0) ||
                ((RW+1)'(row_cur) + (RW+1)'(1)) >= (RW+1)'(MAX_HEIGHT)) begin
               row_in = '0;
            end else begin
               row_in = row_cur + RW'(1);
            end
         end else begin
            col_in = col_cur + CW'(1);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- stage 1: memory data back, write back, shift ----------
   logic [CW-1:0]               s1_idx_ff;
   sgr_pkg::pixel_type          s1_pix_ff;
   logic [sgr_pkg::COORD_W-1:0] s1_ccol_ff, s1_crow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s1_produce_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= req_accept;
         s1_produce_ff <= req_accept && produce;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_idx_ff  <= col_cur;
         s1_pix_ff  <= '{red: req_red, green: req_green, blue: req_blue};
         s1_ccol_ff <= sgr_pkg::COORD_W'(col_cur - CW'(1));
         s1_crow_ff <= sgr_pkg::COORD_W'(row_cur - RW'(1));
      end
   end

   sgr_pkg::ls_ctl_type ls_ctl;
   sgr_pkg::pixel_type  ls_upper, ls_middle;

   assign ls_ctl.rd_en = req_accept;
   assign ls_ctl.wr_en = s1_valid_ff;

   // upper line takes the old middle, middle takes the new pixel
   sgr_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ls_ctl),
      .rd_idx    (col_cur),
      .wr_idx    (s1_idx_ff),
      .wr_upper  (ls_middle),
      .wr_middle (s1_pix_ff),
      .rd_upper  (ls_upper),
      .rd_middle (ls_middle)
   );

   logic signed [sgr_pkg::GRAD_W-1:0] grad_red, grad_green, grad_blue;

   sgr_window u_window (
      .clock      (clock),
      .reset      (reset),
      .shift      (s1_valid_ff),
      .pix_upper  (ls_upper),
      .pix_middle (ls_middle),
      .pix_new    (s1_pix_ff),
      .direction  (direction_ff),
      .grad_red   (grad_red),
      .grad_green (grad_green),
      .grad_blue  (grad_blue)
   );

   // ---------------- stage 2: sums from the updated window, queue ---------
   logic [sgr_pkg::COORD_W-1:0] s2_ccol_ff, s2_crow_ff;
   sgr_pkg::rsp_type            push_data, rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_push_ff <= 1'b0;
      end else begin
         s2_push_ff <= s1_produce_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_ccol_ff <= s1_ccol_ff;
      s2_crow_ff <= s1_crow_ff;
   end

   assign push_data = '{grad_red:      grad_red,
                        grad_green:    grad_green,
                        grad_blue:     grad_blue,
                        center_column: s2_ccol_ff,
                        center_row:    s2_crow_ff};

   sgr_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_push_ff),
      .push_data (push_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .count     (fifo_count)
   );

   assign rsp_grad_red      = rsp_data.grad_red;
   assign rsp_grad_green    = rsp_data.grad_green;
   assign rsp_grad_blue     = rsp_data.grad_blue;
   assign rsp_center_column = rsp_data.center_column;
   assign rsp_center_row    = rsp_data.center_row;

   // ---------------- checks ----------------
   `SGR_ASSERT_NEXT(a_accept_reaches_s1, clock, reset, req_accept, s1_valid_ff)
   `SGR_ASSERT_ALWAYS(a_queue_credit, clock, reset, in_flight <= CR_W'(sgr_pkg::RSP_FIFO_DEPTH))
   `SGR_ASSERT_NEXT(a_frame_start_col, clock, reset, req_accept && req_start_of_frame, col_ff == CW'(1))

endmodule

### tb/sobel_gradient_monitor.sv
module sobel_gradient_monitor #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [sgr_pkg::CHAN_W-1:0]          req_red,
   input  logic [sgr_pkg::CHAN_W-1:0]          req_green,
   input  logic [sgr_pkg::CHAN_W-1:0]          req_blue,
   input  logic                                req_start_of_frame,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [sgr_pkg::GRAD_W-1:0]   rsp_grad_red,
   input  logic signed [sgr_pkg::GRAD_W-1:0]   rsp_grad_green,
   input  logic signed [sgr_pkg::GRAD_W-1:0]   rsp_grad_blue,
   input  logic [sgr_pkg::COORD_W-1:0]         rsp_center_column,
   input  logic [sgr_pkg::COORD_W-1:0]         rsp_center_row,
   input  logic                                csr_write,
   input  logic [sgr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sgr_pkg::CSR_W-1:0]           csr_data,
   output int unsigned                         error_count,
   output int unsigned                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import sgr_pkg::*;

   localparam int MAX_REPORTS = 10;

   // predicted core state
   pixel_type        upper_line  [MAX_WIDTH];
   pixel_type        middle_line [MAX_WIDTH];
   pixel_type        window      [9];
   logic [CSR_W-1:0] line_width_reg;
   logic             direction_reg;
   int unsigned      column_pos;
   int unsigned      row_pos;

   rsp_type gradient_queue [$];

   function automatic int level_of(input pixel_type p, input int ch);
      case (ch)
         0:       return int'(p.red);
         1:       return int'(p.green);
         default: return int'(p.blue);
      endcase
   endfunction

   task automatic clear_model();
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;
      line_width_reg = LINE_WIDTH_RESET;
      direction_reg  = DIR_X;
      column_pos     = 0;
      row_pos        = 0;
      gradient_queue.delete();
   endtask

   task automatic predict_gradient(input pixel_type px, input logic sof);
      int unsigned width_use;
      int unsigned col;
      int unsigned row;
      int unsigned idx;
      pixel_type   up;
      pixel_type   mid;
      int          sum [3];
      rsp_type     want;
      if (sof) begin
         column_pos = 0;
         row_pos    = 0;
      end
      width_use = line_width_reg;
      if (width_use < LINE_WIDTH_MIN) width_use = LINE_WIDTH_MIN;
      if (width_use > MAX_WIDTH) width_use = MAX_WIDTH;
      col = column_pos;
      row = row_pos;
      idx = col % MAX_WIDTH;

      up  = upper_line[idx];
      mid = middle_line[idx];
      for (int i = 0; i < 3; i++) begin
         window[i*3]   = window[i*3+1];
         window[i*3+1] = window[i*3+2];
      end
      window[2] = up;
      window[5] = mid;
      window[8] = px;
      upper_line[idx]  = mid;
      middle_line[idx] = px;

      // window is complete only away from the top and left borders
      if (row >= 2 && col >= 2) begin
         for (int ch = 0; ch < 3; ch++) begin
            if (direction_reg == DIR_X)
               sum[ch] = (level_of(window[2], ch) + 2 * level_of(window[5], ch)
                          + level_of(window[8], ch))
                       - (level_of(window[0], ch) + 2 * level_of(window[3], ch)
                          + level_of(window[6], ch));
            else
               sum[ch] = (level_of(window[6], ch) + 2 * level_of(window[7], ch)
                          + level_of(window[8], ch))
                       - (level_of(window[0], ch) + 2 * level_of(window[1], ch)
                          + level_of(window[2], ch));
         end
         want.grad_red      = GRAD_W'(sum[0]);
         want.grad_green    = GRAD_W'(sum[1]);
         want.grad_blue     = GRAD_W'(sum[2]);
         want.center_column = COORD_W'(col - 1);
         want.center_row    = COORD_W'(row - 1);
         gradient_queue = {gradient_queue, want};
      end

      if (col + 1 >= width_use) begin
         column_pos = 0;
         row_pos    = (row + 1 >= MAX_HEIGHT) ? 0 : row + 1;
      end else begin
         column_pos = col + 1;
      end
   endtask

   task automatic check_result();
      rsp_type got;
      rsp_type want;
      got.grad_red      = rsp_grad_red;
      got.grad_green    = rsp_grad_green;
      got.grad_blue     = rsp_grad_blue;
      got.center_column = rsp_center_column;
      got.center_row    = rsp_center_row;
      if (gradient_queue.size() == 0) begin
         if (error_count < MAX_REPORTS)
            $display("%0t: unexpected result r=%0d g=%0d b=%0d col=%0d row=%0d", $time,
                     got.grad_red, got.grad_green, got.grad_blue,
                     got.center_column, got.center_row);
         error_count++;
      end else begin
         want = gradient_queue.pop_front();
         if (got.grad_red !== want.grad_red || got.grad_green !== want.grad_green ||
             got.grad_blue !== want.grad_blue ||
             got.center_column !== want.center_column ||
             got.center_row !== want.center_row) begin
            if (error_count < MAX_REPORTS)
               $display("%0t: mismatch exp %0d %0d %0d (%0d,%0d) got %0d %0d %0d (%0d,%0d)",
                        $time, want.grad_red, want.grad_green, want.grad_blue,
                        want.center_column, want.center_row,
                        got.grad_red, got.grad_green, got.grad_blue,
                        got.center_column, got.center_row);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_LINE_WIDTH) line_width_reg = csr_data;
            else if (csr_index == CSR_DIRECTION) direction_reg = csr_data[0];
         end
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall)
            predict_gradient('{red: req_red, green: req_green, blue: req_blue},
                             req_start_of_frame);
      end
      pending_count = gradient_queue.size();
   end

endmodule

### tb/tb_sobel_gradient_rgb_core.sv
module tb_sobel_gradient_rgb_core;
   timeunit 1ns;
   timeprecision 1ps;
   import sgr_pkg::*;

   localparam int FRAME_MAX_WIDTH  = 2048;
   localparam int FRAME_MAX_HEIGHT = 2048;
   localparam int RANDOM_ITEMS     = 2000;
   // covers the core pipeline; border pixels leave nothing to wait on
   localparam int QUIET_CYCLES     = 8;
   // long enough for the result queue and both pipeline slots to fill
   localparam int HOLD_OFF_CYCLES  = 120;
   localparam longint TIMEOUT_NS   = 3_000_000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [CHAN_W-1:0]          req_red;
   logic [CHAN_W-1:0]          req_green;
   logic [CHAN_W-1:0]          req_blue;
   logic                       req_start_of_frame;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [GRAD_W-1:0]   rsp_grad_red;
   logic signed [GRAD_W-1:0]   rsp_grad_green;
   logic signed [GRAD_W-1:0]   rsp_grad_blue;
   logic [COORD_W-1:0]         rsp_center_column;
   logic [COORD_W-1:0]         rsp_center_row;
   logic                       csr_write;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_W-1:0]           csr_data;

   int unsigned error_count;
   int unsigned pending_count;

   // idling knobs, percent of cycles
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   // a nonzero value asks the response side for one long stall
   int unsigned hold_request  = 0;
   int unsigned hold_left     = 0;
   // stray start_of_frame marks inside a frame
   bit          sof_noise     = 1'b1;
   int unsigned pixels_sent   = 0;

   sobel_gradient_rgb_core #(
      .MAX_WIDTH  (FRAME_MAX_WIDTH),
      .MAX_HEIGHT (FRAME_MAX_HEIGHT)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_start_of_frame (req_start_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_grad_red       (rsp_grad_red),
      .rsp_grad_green     (rsp_grad_green),
      .rsp_grad_blue      (rsp_grad_blue),
      .rsp_center_column  (rsp_center_column),
      .rsp_center_row     (rsp_center_row),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // predicts every gradient from the accepted requests and scores the results
   sobel_gradient_monitor #(
      .MAX_WIDTH  (FRAME_MAX_WIDTH),
      .MAX_HEIGHT (FRAME_MAX_HEIGHT)
   ) u_monitor (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_start_of_frame (req_start_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_grad_red       (rsp_grad_red),
      .rsp_grad_green     (rsp_grad_green),
      .rsp_grad_blue      (rsp_grad_blue),
      .rsp_center_column  (rsp_center_column),
      .rsp_center_row     (rsp_center_row),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .error_count        (error_count),
      .pending_count      (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Response side: random stalls, or one long counted hold-off on request.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic apply_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 63; stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 63; end
         default:       begin send_idle_pct = 19; stall_pct = 19; end
      endcase
   endtask

   function automatic logic [CHAN_W-1:0] rand_level();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return CHAN_W'($urandom_range(255));
      endcase
   endfunction

   // One pixel request. Valid stays high across back-to-back requests and
   // only drops for an idle gap; the request is taken at an edge where
   // req_stall was low.
   task automatic send_pixel(input pixel_type px, input logic sof);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_red            <= px.red;
      req_green          <= px.green;
      req_blue           <= px.blue;
      req_start_of_frame <= sof;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   // Stop sending, wait out every predicted gradient, then let border pixels
   // still in the pipe drain before anything touches the registers.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Writes both registers on consecutive edges; core must be idle.
   task automatic set_mode(input int unsigned width_raw, input logic dir);
      csr_write <= 1'b1;
      csr_index <= CSR_LINE_WIDTH;
      csr_data  <= CSR_W'(width_raw);
      @(posedge clock);
      csr_index <= CSR_DIRECTION;
      csr_data  <= {{(CSR_W-1){1'b0}}, dir};
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic send_random_row(input int unsigned count, input logic first_sof);
      pixel_type px;
      logic      sof;
      for (int i = 0; i < count; i++) begin
         px.red   = rand_level();
         px.green = rand_level();
         px.blue  = rand_level();
         sof = (i == 0 && first_sof) || (sof_noise && $urandom_range(299) == 0);
         send_pixel(px, sof);
      end
   endtask

   // A frame of random pixels. Now and then a line is cut short: the width
   // is lowered to at most the current column, so the line ends on the next
   // pixel and the rest of the frame runs at the narrower width. Widths only
   // grow at a new frame, so no window ever sees an unwritten line entry.
   task automatic send_random_frame(input int unsigned rows,
                                    inout int unsigned width_raw, input logic dir);
      int unsigned eff;
      int unsigned cut;
      bit          shrunk;
      shrunk = 1'b0;
      for (int r = 0; r < rows; r++) begin
         eff = width_raw;
         if (eff < LINE_WIDTH_MIN) eff = LINE_WIDTH_MIN;
         if (eff > FRAME_MAX_WIDTH) eff = FRAME_MAX_WIDTH;
         if (!shrunk && r >= 2 && eff >= 5 && $urandom_range(9) == 0) begin
            cut = $urandom_range(eff - 1, 3);
            send_random_row(cut, 1'b0);
            wait_quiet();
            width_raw = $urandom_range(cut, 3);
            set_mode(width_raw, dir);
            send_random_row(1, 1'b0);
            shrunk = 1'b1;
         end else if (r == rows - 1 && $urandom_range(7) == 0) begin
            // broken frame: last line may be left incomplete
            send_random_row($urandom_range(eff, 1), 1'b0);
         end else begin
            send_random_row(eff, r == 0);
         end
      end
   endtask

   // 3x3 frame with one edge of full-scale steps; red runs opposite to green
   // and blue so both gradient extremes show up in one result.
   task automatic send_edge_frame(input logic by_row);
      pixel_type px;
      logic      lo;
      logic      hi;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            lo = by_row ? (r == 0) : (c == 0);
            hi = by_row ? (r == 2) : (c == 2);
            px.green = lo ? '0 : hi ? '1 : rand_level();
            px.blue  = lo ? '0 : hi ? '1 : rand_level();
            px.red   = lo ? '1 : hi ? '0 : rand_level();
            send_pixel(px, r == 0 && c == 0);
         end
      end
   endtask

   initial begin : stimulus
      int unsigned start_count;
      int unsigned width_raw;
      int unsigned frames;
      int unsigned phase;
      logic        dir;

      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_red            <= '0;
      req_green          <= '0;
      req_blue           <= '0;
      req_start_of_frame <= 1'b0;
      csr_write          <= 1'b0;
      csr_index          <= CSR_LINE_WIDTH;
      csr_data           <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: both directions at full scale, widths below the minimum
      apply_idling(IDLE_NONE);
      set_mode(0, DIR_X);
      send_edge_frame(1'b0);
      wait_quiet();
      set_mode(2, DIR_Y);
      send_edge_frame(1'b1);
      wait_quiet();

      // back-pressure: response side holds off while requests keep coming,
      // so the result queue fills and req_stall must rise
      set_mode(4, DIR_Y);
      width_raw    = 4;
      hold_request = HOLD_OFF_CYCLES;
      send_random_frame(16, width_raw, DIR_Y);

      // random phases cycling through the idling modes
      phase       = 0;
      start_count = pixels_sent;
      while (pixels_sent - start_count < RANDOM_ITEMS) begin
         apply_idling(idle_mode_type'(phase % 4));
         wait_quiet();
         case ($urandom_range(9))
            0:       width_raw = $urandom_range(2, 0);
            1:       width_raw = $urandom_range(40, 11);
            default: width_raw = $urandom_range(10, 3);
         endcase
         dir = 1'($urandom_range(1));
         set_mode(width_raw, dir);
         frames = $urandom_range(3, 1);
         repeat (frames) send_random_frame($urandom_range(7, 3), width_raw, dir);
         phase++;
      end

      // row counter runs past the last row and wraps to zero
      sof_noise = 1'b0;
      apply_idling(IDLE_NONE);
      wait_quiet();
      width_raw = 3;
      set_mode(width_raw, DIR_X);
      send_random_frame(FRAME_MAX_HEIGHT + 4, width_raw, DIR_X);

      // widest line: all-ones width clamps to the line memory size
      apply_idling(IDLE_RECEIVER);
      wait_quiet();
      width_raw = (1 << CSR_W) - 1;
      set_mode(width_raw, DIR_Y);
      send_random_frame(3, width_raw, DIR_Y);

      wait_quiet();
      if (error_count == 0 && pending_count == 0) begin
         $display("[sobel_gradient_rgb_core] OK");
      end else begin
         $display("[sobel_gradient_rgb_core] ERROR");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("[sobel_gradient_rgb_core] ERROR");
      $finish;
   end

endmodule
